// ----- hw/rtl/rid_pkg.sv -----
// Shared types and constants for the restoring integer divider.
// Used by rid_ctrl, rid_dp and restoring_integer_divider_unit; no dependencies.
package rid_pkg;

	localparam int unsigned DATA_W = 64;
	localparam int unsigned HALF_W = 32;
	localparam int unsigned CNT_W  = 6;

	// operation codes
	localparam logic [1:0] CMD_U32 = 2'd0;
	localparam logic [1:0] CMD_S32 = 2'd1;
	localparam logic [1:0] CMD_U64 = 2'd2;
	localparam logic [1:0] CMD_S64 = 2'd3;

	// fields of the operation code
	localparam int unsigned CMD_SIGNED_BIT = 0;
	localparam int unsigned CMD_WIDE_BIT   = 1;

	// index of the last step for each width
	localparam logic [CNT_W-1:0] TOP_BIT_32 = 6'd31;
	localparam logic [CNT_W-1:0] TOP_BIT_64 = 6'd63;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_NEG,
		ST_STEP,
		ST_FIX
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;    // capture operands and mode
		logic negate;  // take magnitudes, align dividend
		logic step;    // one shift-subtract step
		logic finish;  // sign fix into the output register
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic wide;
	} dp_status_t;

endpackage

// ----- hw/rtl/rid_dp.sv -----
// Datapath of the restoring integer divider: operand, partial remainder,
// quotient and output registers. Depends on rid_pkg.
module rid_dp (
	input  logic                        clk,
	input  rid_pkg::dp_cmd_t            cmd_ctl,
	input  logic [1:0]                  cmd,
	input  logic [rid_pkg::DATA_W-1:0]  dividend,
	input  logic [rid_pkg::DATA_W-1:0]  divisor,
	output rid_pkg::dp_status_t         status,
	output logic [rid_pkg::DATA_W-1:0]  quotient,
	output logic [rid_pkg::DATA_W-1:0]  remainder
);

	localparam int unsigned W = rid_pkg::DATA_W;
	localparam int unsigned H = rid_pkg::HALF_W;

	logic [W-1:0] n_q, d_q, r_q, q_q;
	logic [W-1:0] quotient_q, remainder_q;
	logic         wide_q, signed_q, a_neg_q, b_neg_q;

	logic         a_neg, b_neg;
	logic [W-1:0] n_abs, d_abs;
	logic         carry, take;
	logic [W-1:0] r_sh, diff, r_next;
	logic [W-1:0] q_fix, r_fix;

	always_comb begin
		a_neg = signed_q & (wide_q ? n_q[W-1] : n_q[H-1]);
		b_neg = signed_q & (wide_q ? d_q[W-1] : d_q[H-1]);
		n_abs = a_neg ? (W'(0) - n_q) : n_q;
		d_abs = b_neg ? (W'(0) - d_q) : d_q;
	end

	// one restoring step; the bit shifted out at the top forces a subtract
	always_comb begin
		carry = wide_q ? r_q[W-1] : r_q[H-1];
		r_sh  = {r_q[W-2:0], n_q[W-1]};
		if (!wide_q) begin
			r_sh[W-1:H] = '0;
		end
		take = carry || (r_sh >= d_q);
		diff = r_sh - d_q;
		if (!take) begin
			r_next = r_sh;
		end else if (wide_q) begin
			r_next = diff;
		end else begin
			r_next = {{(W-H){1'b0}}, diff[H-1:0]};
		end
	end

	always_comb begin
		q_fix = (a_neg_q ^ b_neg_q) ? (W'(0) - q_q) : q_q;
		r_fix = a_neg_q ? (W'(0) - r_q) : r_q;
		if (!wide_q) begin
			q_fix[W-1:H] = '0;
			r_fix[W-1:H] = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_ctl.load) begin
			wide_q   <= cmd[rid_pkg::CMD_WIDE_BIT];
			signed_q <= cmd[rid_pkg::CMD_SIGNED_BIT];
			n_q      <= cmd[rid_pkg::CMD_WIDE_BIT] ? dividend
			            : {{(W-H){1'b0}}, dividend[H-1:0]};
			d_q      <= cmd[rid_pkg::CMD_WIDE_BIT] ? divisor
			            : {{(W-H){1'b0}}, divisor[H-1:0]};
			r_q      <= '0;
			q_q      <= '0;
		end
		if (cmd_ctl.negate) begin
			a_neg_q <= a_neg;
			b_neg_q <= b_neg;
			// narrow dividend goes to the top so bits always leave from bit W-1
			n_q     <= wide_q ? n_abs : {n_abs[H-1:0], {(W-H){1'b0}}};
			d_q     <= wide_q ? d_abs : {{(W-H){1'b0}}, d_abs[H-1:0]};
		end
		if (cmd_ctl.step) begin
			r_q <= r_next;
			q_q <= {q_q[W-2:0], take};
			n_q <= {n_q[W-2:0], 1'b0};
		end
		if (cmd_ctl.finish) begin
			quotient_q  <= q_fix;
			remainder_q <= r_fix;
		end
	end

	assign status.wide = wide_q;
	assign quotient    = quotient_q;
	assign remainder   = remainder_q;

endmodule

// ----- hw/rtl/rid_ctrl.sv -----
// Controller of the restoring integer divider: state machine, step counter
// and output valid flag. Depends on rid_pkg.
module rid_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  rid_pkg::dp_status_t  status,
	output rid_pkg::dp_cmd_t     cmd_ctl
);

	rid_pkg::state_t                state_q, state_d;
	logic [rid_pkg::CNT_W-1:0]      count_q;
	logic                           out_valid_q;
	logic                           out_free, last_step;

	assign out_free  = !out_valid_q || !out_stall;
	assign last_step = count_q == (status.wide ? rid_pkg::TOP_BIT_64 : rid_pkg::TOP_BIT_32);

	always_comb begin
		state_d = state_q;
		case (state_q)
			rid_pkg::ST_IDLE: begin
				if (in_valid) state_d = rid_pkg::ST_NEG;
			end
			rid_pkg::ST_NEG:  state_d = rid_pkg::ST_STEP;
			rid_pkg::ST_STEP: begin
				if (last_step) state_d = rid_pkg::ST_FIX;
			end
			rid_pkg::ST_FIX: begin
				if (out_free) state_d = rid_pkg::ST_IDLE;
			end
			default: state_d = rid_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd_ctl  = '0;
		in_stall = 1'b1;
		case (state_q)
			rid_pkg::ST_IDLE: begin
				in_stall     = 1'b0;
				cmd_ctl.load = in_valid;
			end
			rid_pkg::ST_NEG:  cmd_ctl.negate = 1'b1;
			rid_pkg::ST_STEP: cmd_ctl.step   = 1'b1;
			rid_pkg::ST_FIX:  cmd_ctl.finish = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rid_pkg::ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd_ctl.negate) begin
				count_q <= '0;
			end else if (cmd_ctl.step) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd_ctl.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- hw/rtl/restoring_integer_divider_unit.sv -----
// Restoring integer divider, top level: 32/64-bit, signed/unsigned.
// Instantiates rid_ctrl and rid_dp; depends on rid_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries cmd, dividend, divisor.
//   cmd: unsigned 32, signed 32, unsigned 64, signed 64. Narrow modes use
//   the low operand halves and return zero-extended 32-bit results.
//   Output channel (out_valid / out_stall) carries quotient, remainder.
//   One transaction in gives one transaction out.
//   Steps: accept, magnitude, one shift-subtract step per quotient bit
//   (32 or 64), sign fix into the output register.
//   No new transaction is taken until the previous one has finished;
//   the shift-subtract loop runs through one 64-bit subtractor.
//   The result sits in an output register, so a new transaction is taken
//   while the previous result waits. If that result is still stalled when
//   the next one is done, the block waits in its sign-fix state.
//   Zero divisor gives an all-ones magnitude quotient; signed overflow wraps.
//   Reset (arst_n low) empties the block: out_valid low, in_stall low.
module restoring_integer_divider_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  cmd,
	input  logic [rid_pkg::DATA_W-1:0]  dividend,
	input  logic [rid_pkg::DATA_W-1:0]  divisor,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [rid_pkg::DATA_W-1:0]  quotient,
	output logic [rid_pkg::DATA_W-1:0]  remainder
);

	rid_pkg::dp_cmd_t    cmd_ctl;
	rid_pkg::dp_status_t status;

	rid_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd_ctl   (cmd_ctl)
	);

	rid_dp u_dp (
		.clk       (clk),
		.cmd_ctl   (cmd_ctl),
		.cmd       (cmd),
		.dividend  (dividend),
		.divisor   (divisor),
		.status    (status),
		.quotient  (quotient),
		.remainder (remainder)
	);

`ifndef SYNTHESIS
	// busy right after a transaction is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input accepted while previous transaction in flight");

	// never overwrite a result that is still stalled
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_ctl.finish |-> !(out_valid && out_stall))
		else $error("pending result overwritten");

	// a finished transaction is presented on the next cycle
	a_finish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_ctl.finish |=> out_valid)
		else $error("finished result not presented");
`endif

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for restoring_integer_divider_unit.
// Predicts quotient and remainder per transaction; depends on rid_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
	import rid_pkg::*;

	typedef struct packed {
		logic [DATA_W-1:0] quotient;
		logic [DATA_W-1:0] remainder;
	} div_result_t;

	typedef enum int {
		STALL_NONE,
		STALL_RANDOM,
		STALL_LONG
	} stall_mode_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [1:0]        cmd = CMD_U32;
	logic [DATA_W-1:0] dividend = '0;
	logic [DATA_W-1:0] divisor = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [DATA_W-1:0] quotient;
	logic [DATA_W-1:0] remainder;

	div_result_t pending_results[$];
	int          fail_count = 0;
	int          checked_count = 0;
	int          mode_count[4] = '{0, 0, 0, 0};
	int          zero_div_count = 0;
	int          burst_left = 0;

	stall_mode_t stall_mode = STALL_NONE;
	int          seg_left = 0;
	int          hold_left = 0;

	restoring_integer_divider_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.dividend  (dividend),
		.divisor   (divisor),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.quotient  (quotient),
		.remainder (remainder)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shift-subtract division on magnitudes, sign fix-up afterward.
	function automatic div_result_t calc_division(input logic [1:0] op,
			input logic [DATA_W-1:0] a_in, input logic [DATA_W-1:0] b_in);
		logic              wide;
		logic              sgn;
		int                top;
		logic [DATA_W-1:0] mask;
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
		logic [DATA_W-1:0] q;
		logic [DATA_W-1:0] r;
		logic              a_neg;
		logic              b_neg;
		logic              carry;
		div_result_t       res;
		wide = op[CMD_WIDE_BIT];
		sgn = op[CMD_SIGNED_BIT];
		top = wide ? int'(TOP_BIT_64) : int'(TOP_BIT_32);
		mask = wide ? {DATA_W{1'b1}} : {{HALF_W{1'b0}}, {HALF_W{1'b1}}};
		a = a_in & mask;
		b = b_in & mask;
		a_neg = 1'b0;
		b_neg = 1'b0;
		if (sgn) begin
			a_neg = a[top];
			b_neg = b[top];
			if (a_neg)
				a = (-a) & mask;
			if (b_neg)
				b = (-b) & mask;
		end
		q = '0;
		r = '0;
		for (int i = top; i >= 0; i--) begin
			// bit shifted out at the top still counts, as in a width+1 register
			carry = r[top];
			r = ((r << 1) | {{(DATA_W-1){1'b0}}, a[i]}) & mask;
			if (carry || r >= b) begin
				r = (r - b) & mask;
				q[i] = 1'b1;
			end
		end
		if (sgn) begin
			if (a_neg != b_neg)
				q = (-q) & mask;
			if (a_neg)
				r = (-r) & mask;
		end
		res.quotient = q & mask;
		res.remainder = r & mask;
		return res;
	endfunction

	function automatic logic [DATA_W-1:0] rand_operand();
		logic [DATA_W-1:0] v;
		case ($urandom_range(0, 5))
			0: v = {$urandom, $urandom};
			1: v = {$urandom, $urandom} >> $urandom_range(0, 63);
			2: v = 64'($urandom_range(0, 16));
			3: v = -(64'($urandom_range(1, 16)));
			4: begin
				case ($urandom_range(0, 7))
					0: v = '0;
					1: v = 64'd1;
					2: v = '1;
					3: v = 64'h8000_0000_0000_0000;
					4: v = 64'h7FFF_FFFF_FFFF_FFFF;
					5: v = {$urandom, 32'h8000_0000};
					6: v = {$urandom, 32'h7FFF_FFFF};
					default: v = {$urandom, 32'hFFFF_FFFF};
				endcase
			end
			default: v = {$urandom, $urandom >> $urandom_range(0, 31)};
		endcase
		return v;
	endfunction

	// One transaction in; sender idles for a random gap, possibly none, between bursts of random length.
	task automatic send_div(input logic [1:0] op, input logic [DATA_W-1:0] a,
			input logic [DATA_W-1:0] b);
		int          gap;
		logic [DATA_W-1:0] used_b;
		@(negedge clk);
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
			if (gap > 0) begin
				in_valid <= 1'b0;
				cmd <= 2'($urandom);
				dividend <= {$urandom, $urandom};
				divisor <= {$urandom, $urandom};
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
		end
		in_valid <= 1'b1;
		cmd <= op;
		dividend <= a;
		divisor <= b;
		do @(posedge clk); while (in_stall);
		burst_left--;
		pending_results.push_back(calc_division(op, a, b));
		mode_count[op]++;
		used_b = op[CMD_WIDE_BIT] ? b : {{HALF_W{1'b0}}, b[HALF_W-1:0]};
		if (used_b == '0)
			zero_div_count++;
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_unsigned_extremes();
		send_div(CMD_U32, 64'd0, 64'd1);
		send_div(CMD_U32, 64'hFFFF_FFFF, 64'd1);
		send_div(CMD_U32, 64'hFFFF_FFFF, 64'hFFFF_FFFF);
		send_div(CMD_U32, 64'hFFFF_FFFF, 64'h8000_0000);
		// upper halves must be ignored in narrow mode
		send_div(CMD_U32, 64'hDEAD_BEEF_0000_0064, 64'h1234_5678_0000_0007);
		send_div(CMD_U64, 64'hFFFF_FFFF_FFFF_FFFF, 64'd1);
		send_div(CMD_U64, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
		send_div(CMD_U64, 64'h8000_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFF);
		send_div(CMD_U64, 64'h1234_5678_9ABC_DEF0, 64'd3);
	endtask

	task automatic test_signed_rounding();
		send_div(CMD_S32, 64'hABCD_0000_FFFF_FFF9, 64'd2);
		send_div(CMD_S32, 64'd7, 64'h0000_0000_FFFF_FFFE);
		send_div(CMD_S32, 64'hFFFF_FFFF_FFFF_FFF9, 64'h5555_5555_FFFF_FFFE);
		send_div(CMD_S32, 64'h0000_0000_7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		send_div(CMD_S64, -64'sd7, 64'd2);
		send_div(CMD_S64, 64'd7, -64'sd2);
		send_div(CMD_S64, -64'sd7, -64'sd2);
		send_div(CMD_S64, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
	endtask

	task automatic test_zero_divisor();
		send_div(CMD_U32, 64'h0000_0000_1234_5678, 64'hFFFF_FFFF_0000_0000);
		send_div(CMD_S32, 64'h0000_0000_8765_4321, 64'd0);
		send_div(CMD_U64, 64'hFEDC_BA98_7654_3210, 64'd0);
		send_div(CMD_S64, 64'hFEDC_BA98_7654_3210, 64'd0);
	endtask

	task automatic test_signed_overflow();
		send_div(CMD_S32, 64'h0000_0000_8000_0000, 64'h0000_0000_FFFF_FFFF);
		send_div(CMD_S64, 64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
	endtask

	task automatic test_random_mix(input int n_items);
		for (int k = 0; k < n_items; k++) begin
			send_div(2'($urandom_range(0, 3)), rand_operand(), rand_operand());
			// hold off once midway until everything has come back
			if (k == n_items / 2)
				drain_results();
		end
	endtask

	// Receiver stall pattern: segments of no stall, random stall, long holds.
	always @(negedge clk) begin
		if (seg_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 2));
			seg_left = $urandom_range(100, 400);
		end
		seg_left--;
		case (stall_mode)
			STALL_NONE: out_stall <= 1'b0;
			STALL_RANDOM: out_stall <= ($urandom_range(0, 3) == 0);
			default: begin
				if (hold_left > 0) begin
					hold_left--;
					out_stall <= 1'b1;
				end else if ($urandom_range(0, 9) == 0) begin
					hold_left = $urandom_range(1, 80);
					out_stall <= 1'b1;
				end else begin
					out_stall <= 1'b0;
				end
			end
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result with no transaction outstanding: quotient %h remainder %h",
					quotient, remainder);
				fail_count++;
			end else begin
				div_result_t exp_res;
				exp_res = pending_results.pop_front();
				checked_count++;
				if (quotient !== exp_res.quotient) begin
					$error("quotient mismatch: expected %h, got %h",
						exp_res.quotient, quotient);
					fail_count++;
				end
				if (remainder !== exp_res.remainder) begin
					$error("remainder mismatch: expected %h, got %h",
						exp_res.remainder, remainder);
					fail_count++;
				end
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_unsigned_extremes();
		test_signed_rounding();
		test_zero_divisor();
		test_signed_overflow();
		drain_results();
		test_random_mix(800);
		drain_results();
		repeat (80) @(posedge clk);
		$display("Checked %0d results: %0d u32, %0d s32, %0d u64, %0d s64 transactions,",
			checked_count, mode_count[CMD_U32], mode_count[CMD_S32],
			mode_count[CMD_U64], mode_count[CMD_S64]);
		$display("%0d with zero divisor, under random input gaps and output stalls.",
			zero_div_count);
		if (fail_count == 0 && pending_results.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/rid_pkg.sv
hw/rtl/rid_dp.sv
hw/rtl/rid_ctrl.sv
hw/rtl/restoring_integer_divider_unit.sv
test/tb_top.sv
